// ----- rtl/hbdbm_pkg.sv -----
// Package for the handheld bus decoder with its cartridge bank mapper.
// Holds target codes, mapper codes, register indexes and stream widths.
// No dependencies; imported by the top level and by its port checker.
package hbdbm_pkg;

	// Result target codes
	localparam logic [3:0] T_ROM   = 4'd0;
	localparam logic [3:0] T_VRAM  = 4'd1;
	localparam logic [3:0] T_CRAM  = 4'd2;
	localparam logic [3:0] T_RTC   = 4'd3;
	localparam logic [3:0] T_WRAM  = 4'd4;
	localparam logic [3:0] T_OAM   = 4'd5;
	localparam logic [3:0] T_HRAM  = 4'd6;
	localparam logic [3:0] T_IO    = 4'd7;
	localparam logic [3:0] T_SOUND = 4'd8;
	localparam logic [3:0] T_BANK  = 4'd9;
	localparam logic [3:0] T_FF    = 4'd10;
	localparam logic [3:0] T_ZERO  = 4'd11;
	localparam logic [3:0] T_DROP  = 4'd12;

	// Mapper kinds after folding unknown codes to none
	localparam logic [2:0] MBC_NONE = 3'd0;
	localparam logic [2:0] MBC_1    = 3'd1;
	localparam logic [2:0] MBC_2    = 3'd2;
	localparam logic [2:0] MBC_3    = 3'd3;
	localparam logic [2:0] MBC_5    = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_MAPPER_TYPE    = 2'd0;
	localparam logic [1:0] REG_ROM_BANK_BITS  = 2'd1;
	localparam logic [1:0] REG_RAM_BANK_COUNT = 2'd2;
	localparam logic [1:0] REG_HAS_CART_RAM   = 2'd3;

	localparam int CFG_DATA_W = 5;
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 40;

	typedef struct packed {
		logic [7:0]  data_out;
		logic        is_write;
		logic [22:0] offset;
		logic [3:0]  target;
	} result_t;

endpackage

// ----- rtl/handheld_bus_decoder_with_bank_mapper_unit.sv -----
// Top level of the handheld bus decoder and cartridge bank controller.
// Depends on hbdbm_pkg for target codes, mapper codes and register indexes.
//
//  channel   | direction | transfer content
//  ----------+-----------+----------------------------------------------
//  s_axis    | in        | one bus access: kind, addr, wdata
//  m_axis    | out       | one routing result: target, offset, is_write, data_out
//  cfg       | in        | register write: mapper, ROM bank bits, RAM banks, RAM present
//
// Every accepted access yields exactly one result, through the input register and
// then the result register; one access is taken per cycle while the output side
// is not stalled. The address decode and the bank register update lie between
// the two registers.
// arst_n resets the bank registers (ROM bank to one), the configuration (ROM bank
// bits to one, the rest to zero) and the valid flags. A stalled output holds its
// result; the input register then fills and s_tready falls until the result is taken.
module handheld_bus_decoder_with_bank_mapper_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Access stream; s_tdata from bit 0: kind, addr[15:0], wdata[7:0], zero pad
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hbdbm_pkg::S_DATA_W-1:0]  s_tdata,
	// Result stream; m_tdata from bit 0: target[3:0], offset[22:0], is_write,
	// data_out[7:0], zero pad
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hbdbm_pkg::M_DATA_W-1:0]  m_tdata,
	// Configuration write port
	input  logic                            cfg_wen,
	input  logic [1:0]                      cfg_idx,
	input  logic [hbdbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import hbdbm_pkg::*;

	// Configuration registers
	logic [2:0] mapper_type_q;
	logic [3:0] rom_bank_bits_q;
	logic [4:0] ram_bank_count_q;
	logic       has_cart_ram_q;

	// Cartridge bank state
	logic [8:0] rom_bank_q;
	logic [7:0] ram_bank_q;
	logic       ram_enabled_q;
	logic       mode_select_q;

	// Input stage
	logic        in_valid_s1;
	logic        in_kind_s1;
	logic [15:0] in_addr_s1;
	logic [7:0]  in_wdata_s1;

	// Result stage
	logic        out_valid_s2;
	result_t     out_res_s2;

	logic        advance;
	logic [2:0]  mbc;
	logic [3:0]  bank_bits;
	logic [8:0]  rom_mask;
	logic [8:0]  rom_bank_nxt;
	logic [7:0]  ram_bank_nxt;
	logic        ram_enabled_nxt;
	logic        mode_select_nxt;
	logic [8:0]  rom_win_bank;
	logic [7:0]  io_lo;
	logic        io_rd_ok;
	logic        io_wr_ok;
	logic        wr;
	logic [3:0]  region;
	logic [8:0]  rb_tmp;
	result_t     res;

	// The input register advances whenever the result register is free or
	// being drained this cycle, so a full pipe still moves one item a cycle.
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;
	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, out_res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_type_q    <= MBC_NONE;
			rom_bank_bits_q  <= 4'd1;
			ram_bank_count_q <= 5'd0;
			has_cart_ram_q   <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_MAPPER_TYPE:    mapper_type_q    <= cfg_wdata[2:0];
				REG_ROM_BANK_BITS:  rom_bank_bits_q  <= cfg_wdata[3:0];
				REG_RAM_BANK_COUNT: ram_bank_count_q <= cfg_wdata[4:0];
				REG_HAS_CART_RAM:   has_cart_ram_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Unknown mapper codes behave as no mapper at all.
	always_comb begin
		case (mapper_type_q) inside
			MBC_1, MBC_2, MBC_3, MBC_5: mbc = mapper_type_q;
			default:                    mbc = MBC_NONE;
		endcase
	end

	// ROM bank mask: bank bit count saturates at nine.
	assign bank_bits = (rom_bank_bits_q > 4'd9) ? 4'd9 : rom_bank_bits_q;
	assign rom_mask  = 9'(({1'b0, 9'h1FF} << bank_bits) ^ 10'h3FF);

	assign wr     = in_kind_s1;
	assign region = in_addr_s1[15:12];

	// Bank register update for a write below 0x8000.
	always_comb begin
		rom_bank_nxt    = rom_bank_q;
		ram_bank_nxt    = ram_bank_q;
		ram_enabled_nxt = ram_enabled_q;
		mode_select_nxt = mode_select_q;
		rb_tmp          = rom_bank_q;
		if (region <= 4'd1) begin
			// RAM enable; on MBC2 address bit 4 blocks this range
			if (!(mbc == MBC_2 && in_addr_s1[4]) && mbc != MBC_NONE && has_cart_ram_q)
				ram_enabled_nxt = (in_wdata_s1[3:0] == 4'hA);
		end else if (region <= 4'd3) begin
			if (region == 4'd2 && mbc == MBC_5) begin
				rom_bank_nxt = {rom_bank_q[8], in_wdata_s1} & rom_mask;
			end else begin
				if (mbc == MBC_1) begin
					rb_tmp = {2'b00, rom_bank_q[6:5], in_wdata_s1[4:0]};
					// A zero low field is taken as one instead.
					if (in_wdata_s1[4:0] == 5'd0)
						rb_tmp[0] = 1'b1;
				end else if (mbc == MBC_2 && in_addr_s1[4]) begin
					rb_tmp = {5'd0, in_wdata_s1[3:0]};
					if (in_wdata_s1[3:0] == 4'd0)
						rb_tmp = 9'd1;
				end else if (mbc == MBC_3) begin
					rb_tmp = {2'b00, in_wdata_s1[6:0]};
					if (in_wdata_s1[6:0] == 7'd0)
						rb_tmp = 9'd1;
				end else if (mbc == MBC_5) begin
					rb_tmp = {in_wdata_s1[0], rom_bank_q[7:0]};
				end
				rom_bank_nxt = rb_tmp & rom_mask;
			end
		end else if (region <= 4'd5) begin
			if (mbc == MBC_1) begin
				ram_bank_nxt = {6'd0, in_wdata_s1[1:0]};
				rom_bank_nxt = {2'b00, in_wdata_s1[1:0], rom_bank_q[4:0]} & rom_mask;
			end else if (mbc == MBC_3) begin
				ram_bank_nxt = in_wdata_s1;
			end else if (mbc == MBC_5) begin
				ram_bank_nxt = {4'd0, in_wdata_s1[3:0]};
			end
		end else begin
			mode_select_nxt = in_wdata_s1[0];
		end
	end

	// I/O register map: readable and writable low address bytes.
	assign io_lo = in_addr_s1[7:0];
	always_comb begin
		io_rd_ok = 1'b0;
		io_wr_ok = 1'b0;
		unique case (io_lo) inside
			[8'h00:8'h02], [8'h04:8'h07], 8'h0F, 8'hFF: begin
				io_rd_ok = 1'b1;
				io_wr_ok = 1'b1;
			end
			8'h44: io_rd_ok = 1'b1;
			[8'h40:8'h43], [8'h45:8'h4B]: begin
				io_rd_ok = 1'b1;
				io_wr_ok = 1'b1;
			end
			8'h50: io_wr_ok = 1'b1;
			default: ;
		endcase
	end

	// MBC1 in mode one keeps the upper ROM bank bits out of the window.
	assign rom_win_bank = (mbc == MBC_1 && mode_select_q) ?
		{4'd0, rom_bank_q[4:0]} : rom_bank_q;

	// Address decode and offset
	always_comb begin
		res.target = T_DROP;
		res.offset = 23'd0;
		if (!in_addr_s1[15]) begin
			if (wr) begin
				res.target = T_BANK;
				res.offset = {7'd0, in_addr_s1};
			end else if (!in_addr_s1[14]) begin
				res.target = T_ROM;
				res.offset = {7'd0, in_addr_s1};
			end else begin
				res.target = T_ROM;
				res.offset = {rom_win_bank, in_addr_s1[13:0]};
			end
		end else if (in_addr_s1 < 16'hA000) begin
			res.target = T_VRAM;
			res.offset = {10'd0, in_addr_s1[12:0]};
		end else if (in_addr_s1 < 16'hC000) begin
			if (has_cart_ram_q && ram_enabled_q) begin
				if (mbc == MBC_3 && ram_bank_q >= 8'h08) begin
					res.target = T_RTC;
					res.offset = {15'd0, 8'(ram_bank_q - 8'h08)};
				end else if ((mode_select_q || mbc != MBC_1) &&
						ram_bank_q < {3'd0, ram_bank_count_q}) begin
					res.target = T_CRAM;
					res.offset = {2'd0, ram_bank_q, in_addr_s1[12:0]};
				end else if (!wr || ram_bank_count_q != 5'd0) begin
					// Bank out of range, or MBC1 in mode zero: fall back to the unbanked window.
					res.target = T_CRAM;
					res.offset = {10'd0, in_addr_s1[12:0]};
				end
			end else if (!wr) begin
				res.target = T_ZERO;
			end
		end else if (in_addr_s1 < 16'hFE00) begin
			// Work RAM and its echo share the low 13 address bits.
			res.target = T_WRAM;
			res.offset = {10'd0, in_addr_s1[12:0]};
		end else if (in_addr_s1 < 16'hFEA0) begin
			res.target = T_OAM;
			res.offset = {15'd0, in_addr_s1[7:0]};
		end else if (in_addr_s1 < 16'hFF00) begin
			if (!wr)
				res.target = T_FF;
		end else if (in_addr_s1[7] && in_addr_s1 != 16'hFFFF) begin
			res.target = T_HRAM;
			res.offset = {16'd0, in_addr_s1[6:0]};
		end else if (io_lo >= 8'h10 && io_lo <= 8'h3F) begin
			res.target = T_SOUND;
			res.offset = {15'd0, io_lo};
		end else if (wr) begin
			if (io_wr_ok) begin
				res.target = T_IO;
				res.offset = {15'd0, io_lo};
			end
		end else if (io_rd_ok) begin
			res.target = T_IO;
			res.offset = {15'd0, io_lo};
		end else begin
			res.target = T_FF;
		end
		res.is_write = wr && (res.target != T_DROP);
		res.data_out = res.is_write ? in_wdata_s1 : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_kind_s1  <= s_tdata[0];
			in_addr_s1  <= s_tdata[16:1];
			in_wdata_s1 <= s_tdata[24:17];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_res_s2 <= res;
	end

	// Bank state changes in access order, as each write leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q    <= 9'd1;
			ram_bank_q    <= 8'd0;
			ram_enabled_q <= 1'b0;
			mode_select_q <= 1'b0;
		end else if (advance && wr && !in_addr_s1[15]) begin
			rom_bank_q    <= rom_bank_nxt;
			ram_bank_q    <= ram_bank_nxt;
			ram_enabled_q <= ram_enabled_nxt;
			mode_select_q <= mode_select_nxt;
		end
	end

endmodule

// ----- rtl/hbdbm_checker.sv -----
// Port checker for the handheld bus decoder, with its bind statement.
// Depends on hbdbm_pkg for target codes; sees the top level's ports only.
module hbdbm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [hbdbm_pkg::S_DATA_W-1:0]  s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [hbdbm_pkg::M_DATA_W-1:0]  m_tdata,
	input logic                            cfg_wen,
	input logic [1:0]                      cfg_idx,
	input logic [hbdbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import hbdbm_pkg::*;

	// A stalled result holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// With the output empty the input side is always open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= T_DROP)
		else $error("target code out of range");

	// Write flag and write byte agree with the target.
	a_write_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[27] ? m_tdata[3:0] != T_DROP : m_tdata[35:28] == 8'd0))
		else $error("write flag inconsistent with target or data");

	// Fixed-value and dropped results carry no offset.
	a_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:0] == T_FF || m_tdata[3:0] == T_ZERO ||
			m_tdata[3:0] == T_DROP) |-> m_tdata[26:4] == 23'd0)
		else $error("nonzero offset on a fixed or dropped result");

endmodule

bind handheld_bus_decoder_with_bank_mapper_unit hbdbm_checker u_hbdbm_checker (.*);

// ----- dv/handheld_bus_decoder_with_bank_mapper_unit_test.sv -----
// Self-checking testbench for handheld_bus_decoder_with_bank_mapper_unit: a directed access
// table, then randomized phases under changing cartridge settings, checked by a bus router model.
// Depends on hbdbm_pkg and the RTL top level only.
module handheld_bus_decoder_with_bank_mapper_unit_test;
	import hbdbm_pkg::*;

	// Access kinds carried in bit 0 of s_tdata.
	localparam logic ACC_READ  = 1'b0;
	localparam logic ACC_WRITE = 1'b1;

	// Mapper codes with no mapper behind them; the block treats them as none.
	localparam logic [2:0] MBC_UNKNOWN_4 = 3'd4;
	localparam logic [2:0] MBC_UNKNOWN_7 = 3'd7;

	// The LY register accepts reads but drops writes.
	localparam logic [7:0] IO_LY = 8'h44;

	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 125;
	localparam int HOLD_PHASE  = 3;
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 1000;
	localparam int REPORT_CAP  = 100;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_wen   = 1'b0;
	logic [1:0]            cfg_idx   = REG_MAPPER_TYPE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	handheld_bus_decoder_with_bank_mapper_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One row of the directed table: either a register setting, applied while the bus
	// is quiet, or a single access. Rows with a typed result are checked against that
	// value; the others go through the router model like the random part.
	typedef struct packed {
		logic       is_setup;
		logic [2:0] mapper;
		logic [3:0] rom_bits;
		logic [4:0] ram_banks;
		logic       has_ram;
		logic       kind;
		logic [15:0] addr;
		logic [7:0] wdata;
		logic       typed;
		result_t    want;
	} plan_row_t;

	// Settings as the block holds them, mirrored when they are written.
	logic [2:0] cfg_mapper    = MBC_NONE;
	logic [3:0] cfg_rom_bits  = 4'd1;
	logic [4:0] cfg_ram_banks = 5'd0;
	logic       cfg_has_ram   = 1'b0;

	// Cartridge bank state as it stands after every accepted access.
	logic [8:0] cur_rom_bank = 9'd1;
	logic [7:0] cur_ram_bank = 8'd0;
	logic       cram_enabled = 1'b0;
	logic       banking_mode = 1'b0;

	// Routing results that the block still owes, oldest first.
	result_t pending_routes[$];

	int error_count    = 0;
	int accesses_sent  = 0;
	int routes_checked = 0;
	int settings_used  = 0;
	int idle_cycles    = 0;

	// Handshake shaping. The sink owns the long hold-off count; the stimulus only asks.
	bit tx_idle_on   = 1'b1;
	bit rx_idle_on   = 1'b1;
	bit quiet_phase  = 1'b0;
	bit hold_request = 1'b0;
	int hold_left    = 0;
	int sink_gap     = 0;

	// ------------------------------------------------------------------
	// Router model
	// ------------------------------------------------------------------

	// Codes 0, 4, 6 and 7 all behave as a cartridge with no mapper.
	function automatic logic [2:0] fold_mapper(input logic [2:0] code);
		case (code) inside
			MBC_1, MBC_2, MBC_3, MBC_5: return code;
			default: return MBC_NONE;
		endcase
	endfunction

	// The bank count saturates at 2^9; a width of zero leaves only bank 0.
	function automatic logic [8:0] clip_rom_bank(input int unsigned bank);
		int unsigned width;
		width = (cfg_rom_bits > 4'd9) ? 9 : cfg_rom_bits;
		return 9'(bank & ((32'd1 << width) - 1));
	endfunction

	function automatic logic io_readable(input logic [7:0] lo);
		return lo <= 8'h02 || (lo >= 8'h04 && lo <= 8'h07) || lo == 8'h0F ||
			(lo >= 8'h40 && lo <= 8'h4B) || lo == 8'hFF;
	endfunction

	function automatic logic io_writable(input logic [7:0] lo);
		return lo <= 8'h02 || (lo >= 8'h04 && lo <= 8'h07) || lo == 8'h0F ||
			(lo >= 8'h40 && lo <= 8'h4B && lo != IO_LY) || lo == 8'h50 || lo == 8'hFF;
	endfunction

	// A write below 0x8000 lands in the mapper registers; the 4 KiB region picks which.
	function automatic void update_banks(input logic [15:0] a, input logic [7:0] v,
			input logic [2:0] m);
		int unsigned bank;
		bank = cur_rom_bank;
		case (a[15:12]) inside
			4'h0, 4'h1: begin
				// MBC2 decodes RAM enable only with address bit 4 clear.
				if (!(m == MBC_2 && a[4]) && m != MBC_NONE && cfg_has_ram)
					cram_enabled = (v[3:0] == 4'hA);
			end
			4'h2, 4'h3: begin
				if (a[15:12] == 4'h2 && m == MBC_5) begin
					// MBC5 low eight bank bits.
					bank = (bank & 'h100) | v;
				end else begin
					case (m)
						MBC_1: begin
							bank = (v & 'h1F) | (bank & 'h60);
							if ((bank & 'h1F) == 0)
								bank++;
						end
						MBC_2: begin
							if (a[4]) begin
								bank = v & 'h0F;
								if (bank == 0)
									bank = 1;
							end
						end
						MBC_3: begin
							bank = v & 'h7F;
							if (bank == 0)
								bank = 1;
						end
						MBC_5: bank = ((v & 1) << 8) | (bank & 'hFF);
						default: ;
					endcase
				end
				// Masking applies even when the mapper ignored the write, so a zero
				// bank can come out of it.
				cur_rom_bank = clip_rom_bank(bank);
			end
			4'h4, 4'h5: begin
				case (m)
					MBC_1: begin
						cur_ram_bank = {6'd0, v[1:0]};
						cur_rom_bank = clip_rom_bank({v[1:0], 5'd0} | (bank & 'h1F));
					end
					MBC_3: cur_ram_bank = v;
					MBC_5: cur_ram_bank = {4'd0, v[3:0]};
					default: ;
				endcase
			end
			default: banking_mode = v[0];
		endcase
	endfunction

	// Works out where one access goes, updating the bank state on mapper writes.
	function automatic result_t route_access(input logic wr, input logic [15:0] a,
			input logic [7:0] v);
		logic [2:0]  m;
		logic [3:0]  t;
		int unsigned off;
		int unsigned bank;
		result_t     r;
		m   = fold_mapper(cfg_mapper);
		t   = T_DROP;
		off = 0;
		if (a < 16'h8000) begin
			if (wr) begin
				update_banks(a, v, m);
				t   = T_BANK;
				off = a;
			end else if (a < 16'h4000) begin
				t   = T_ROM;
				off = a;
			end else begin
				// MBC1 in RAM banking mode ignores the upper bank bits here.
				bank = (m == MBC_1 && banking_mode) ? (cur_rom_bank & 'h1F) : cur_rom_bank;
				t    = T_ROM;
				off  = bank * 'h4000 + (a & 'h3FFF);
			end
		end else if (a < 16'hA000) begin
			t   = T_VRAM;
			off = a - 16'h8000;
		end else if (a < 16'hC000) begin
			if (cfg_has_ram && cram_enabled) begin
				if (m == MBC_3 && cur_ram_bank >= 8'h08) begin
					t   = T_RTC;
					off = cur_ram_bank - 8'h08;
				end else if ((banking_mode || m != MBC_1) && cur_ram_bank < cfg_ram_banks) begin
					t   = T_CRAM;
					off = cur_ram_bank * 'h2000 + (a & 'h1FFF);
				end else if (!wr || cfg_ram_banks != 0) begin
					// Bank out of range, or MBC1 in mode zero, falls back to the first 8 KiB.
					t   = T_CRAM;
					off = a & 'h1FFF;
				end
			end else if (!wr) begin
				t = T_ZERO;
			end
		end else if (a < 16'hE000) begin
			t   = T_WRAM;
			off = a - 16'hC000;
		end else if (a < 16'hFE00) begin
			t   = T_WRAM;
			off = a - 16'hE000;
		end else if (a < 16'hFEA0) begin
			t   = T_OAM;
			off = a - 16'hFE00;
		end else if (a < 16'hFF00) begin
			if (!wr)
				t = T_FF;
		end else if (a >= 16'hFF80 && a < 16'hFFFF) begin
			t   = T_HRAM;
			off = a - 16'hFF80;
		end else if (a >= 16'hFF10 && a <= 16'hFF3F) begin
			t   = T_SOUND;
			off = a[7:0];
		end else if (wr) begin
			if (io_writable(a[7:0])) begin
				t   = T_IO;
				off = a[7:0];
			end
		end else if (io_readable(a[7:0])) begin
			t   = T_IO;
			off = a[7:0];
		end else begin
			t = T_FF;
		end
		r.target   = t;
		r.offset   = off[22:0];
		r.is_write = wr && t != T_DROP;
		r.data_out = r.is_write ? v : 8'd0;
		return r;
	endfunction

	function automatic result_t make_result(input logic [3:0] t, input logic [22:0] off,
			input logic w, input logic [7:0] d);
		result_t r;
		r.target   = t;
		r.offset   = off;
		r.is_write = w;
		r.data_out = d;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table rows
	// ------------------------------------------------------------------

	function automatic plan_row_t setup_row(input logic [2:0] mapper, input logic [3:0] rom_bits,
			input logic [4:0] ram_banks, input logic has_ram);
		plan_row_t r;
		r           = '0;
		r.is_setup  = 1'b1;
		r.mapper    = mapper;
		r.rom_bits  = rom_bits;
		r.ram_banks = ram_banks;
		r.has_ram   = has_ram;
		return r;
	endfunction

	function automatic plan_row_t access_row(input logic kind, input logic [15:0] addr,
			input logic [7:0] wdata);
		plan_row_t r;
		r       = '0;
		r.kind  = kind;
		r.addr  = addr;
		r.wdata = wdata;
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic kind, input logic [15:0] addr,
			input logic [7:0] wdata, input result_t want);
		plan_row_t r;
		r       = access_row(kind, addr, wdata);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Bus driving
	// ------------------------------------------------------------------

	// Offers one access and waits for its transfer. The expected route is worked out at
	// the edge of the transfer, so bank state follows the order the block sees. s_tvalid
	// stays high afterwards; the next access or a gap decides what happens to it.
	task automatic send_access(input logic kind, input logic [15:0] addr,
			input logic [7:0] wdata, input logic typed, input result_t want);
		result_t modeled;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, wdata, addr, kind};
		do
			@(posedge clk);
		while (!s_tready);
		modeled = route_access(kind == ACC_WRITE, addr, wdata);
		pending_routes.push_back(typed ? want : modeled);
		accesses_sent++;
	endtask

	// Random idle burst on the sending side, never during the sink's long hold-off,
	// so that the block really backs up then.
	task automatic sender_gap();
		int n;
		if (tx_idle_on && !quiet_phase && hold_left == 0 && !hold_request &&
				$urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every owed result has come back. Each access yields
	// exactly one result, so after that the pipeline is empty; a few spare cycles cover
	// the two-stage latency anyway.
	task automatic settle_bus();
		s_tvalid <= 1'b0;
		while (pending_routes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all four registers on back-to-back cycles; only called with the bus settled.
	task automatic set_config(input logic [2:0] mapper, input logic [3:0] rom_bits,
			input logic [4:0] ram_banks, input logic has_ram);
		cfg_wen   <= 1'b1;
		cfg_idx   <= REG_MAPPER_TYPE;
		cfg_wdata <= CFG_DATA_W'(mapper);
		@(posedge clk);
		cfg_idx   <= REG_ROM_BANK_BITS;
		cfg_wdata <= CFG_DATA_W'(rom_bits);
		@(posedge clk);
		cfg_idx   <= REG_RAM_BANK_COUNT;
		cfg_wdata <= CFG_DATA_W'(ram_banks);
		@(posedge clk);
		cfg_idx   <= REG_HAS_CART_RAM;
		cfg_wdata <= CFG_DATA_W'(has_ram);
		@(posedge clk);
		cfg_wen       <= 1'b0;
		cfg_mapper    = mapper;
		cfg_rom_bits  = rom_bits;
		cfg_ram_banks = ram_banks;
		cfg_has_ram   = has_ram;
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// Result sink: random stalls, a long hold-off on request, none in the quiet phase.
	// ------------------------------------------------------------------
	initial begin : sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap != 0 && !quiet_phase) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (rx_idle_on && !quiet_phase && $urandom_range(0, 7) == 0) begin
				// This cycle is the first of the burst.
				sink_gap = $urandom_range(1, 15) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking, one transfer at a time against the oldest owed route.
	// ------------------------------------------------------------------
	task automatic note_mismatch(input string field, input int unsigned want,
			input int unsigned seen);
		error_count++;
		// Past the cap the count still grows, but the log stays readable.
		if (error_count <= REPORT_CAP)
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, seen);
	endtask

	always @(posedge clk) begin : check_routes
		result_t seen;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = result_t'(m_tdata[35:0]);
			if (pending_routes.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_CAP)
					$error("result with nothing owed: target %0d offset 0x%0h",
						seen.target, seen.offset);
			end else begin
				want = pending_routes.pop_front();
				routes_checked++;
				if (seen.target !== want.target)
					note_mismatch("target", want.target, seen.target);
				if (seen.offset !== want.offset)
					note_mismatch("offset", want.offset, seen.offset);
				if (seen.is_write !== want.is_write)
					note_mismatch("is_write", want.is_write, seen.is_write);
				if (seen.data_out !== want.data_out)
					note_mismatch("data_out", want.data_out, seen.data_out);
			end
		end
	end

	// Watchdog: any transfer on either stream counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results still owed",
					STALL_LIMIT, pending_routes.size());
				$display("handheld_bus_decoder_with_bank_mapper_unit test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		plan_row_t   plan[$];
		logic        kind;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [2:0]  mapper;
		logic [3:0]  rom_bits;
		logic [4:0]  ram_banks;
		logic        has_ram;
		int          phase;
		int          n;
		int          pick;

		// Settings right after reset: no mapper, two ROM banks, no cartridge RAM.
		// These first results follow from the address map alone.
		plan.push_back(known_row(ACC_READ, 16'h0000, 8'h00,
			make_result(T_ROM, 23'h0, 1'b0, 8'h00)));
		plan.push_back(known_row(ACC_READ, 16'h4000, 8'h00,
			make_result(T_ROM, 23'h4000, 1'b0, 8'h00)));
		plan.push_back(known_row(ACC_READ, 16'hFFFF, 8'h00,
			make_result(T_IO, 23'hFF, 1'b0, 8'h00)));
		plan.push_back(known_row(ACC_WRITE, 16'hFFFF, 8'hFF,
			make_result(T_IO, 23'hFF, 1'b1, 8'hFF)));
		// Cartridge RAM absent: reads give zero, writes vanish.
		plan.push_back(known_row(ACC_READ, 16'hA000, 8'h00,
			make_result(T_ZERO, 23'h0, 1'b0, 8'h00)));
		plan.push_back(known_row(ACC_WRITE, 16'hBFFF, 8'hAA,
			make_result(T_DROP, 23'h0, 1'b0, 8'h00)));
		// The unusable hole above OAM.
		plan.push_back(known_row(ACC_READ, 16'hFEA0, 8'h00,
			make_result(T_FF, 23'h0, 1'b0, 8'h00)));
		plan.push_back(known_row(ACC_WRITE, 16'hFEFF, 8'h5A,
			make_result(T_DROP, 23'h0, 1'b0, 8'h00)));
		// LY is read-only and 0xFF03 is not a register at all.
		plan.push_back(known_row(ACC_WRITE, 16'hFF44, 8'h12,
			make_result(T_DROP, 23'h0, 1'b0, 8'h00)));
		plan.push_back(known_row(ACC_READ, 16'hFF03, 8'h00,
			make_result(T_FF, 23'h0, 1'b0, 8'h00)));
		// With no mapper a bank write still counts as a performed write.
		plan.push_back(known_row(ACC_WRITE, 16'h7FFF, 8'h00,
			make_result(T_BANK, 23'h7FFF, 1'b1, 8'h00)));

		// MBC1 with an oversized bank width, which saturates at nine bits.
		plan.push_back(setup_row(MBC_1, 4'd15, 5'd4, 1'b1));
		plan.push_back(known_row(ACC_WRITE, 16'h0000, 8'h0A,
			make_result(T_BANK, 23'h0, 1'b1, 8'h0A)));
		plan.push_back(access_row(ACC_WRITE, 16'h2000, 8'h00));
		plan.push_back(access_row(ACC_WRITE, 16'h4000, 8'h03));
		plan.push_back(access_row(ACC_WRITE, 16'h6000, 8'h01));
		plan.push_back(access_row(ACC_READ, 16'h7FFF, 8'h00));
		plan.push_back(access_row(ACC_READ, 16'hBFFF, 8'h00));

		// MBC5 with a single ROM bank: any bank number masks down to zero.
		plan.push_back(setup_row(MBC_5, 4'd0, 5'd16, 1'b1));
		plan.push_back(access_row(ACC_WRITE, 16'h2000, 8'hFF));
		plan.push_back(access_row(ACC_READ, 16'h4000, 8'h00));
		plan.push_back(access_row(ACC_WRITE, 16'h1000, 8'h0A));
		plan.push_back(access_row(ACC_WRITE, 16'hA000, 8'h55));

		// MBC3 without RAM banks: clock registers, then an out-of-range bank.
		plan.push_back(setup_row(MBC_3, 4'd9, 5'd0, 1'b1));
		plan.push_back(access_row(ACC_WRITE, 16'h4000, 8'h08));
		plan.push_back(access_row(ACC_READ, 16'hA123, 8'h00));
		plan.push_back(access_row(ACC_WRITE, 16'h4000, 8'h02));
		plan.push_back(access_row(ACC_WRITE, 16'hB000, 8'h77));
		plan.push_back(access_row(ACC_READ, 16'hB000, 8'h00));

		// An unknown mapper code, then MBC2 with its address-bit-4 register select.
		plan.push_back(setup_row(MBC_UNKNOWN_4, 4'd4, 5'd2, 1'b1));
		plan.push_back(access_row(ACC_WRITE, 16'h2000, 8'h05));
		plan.push_back(setup_row(MBC_2, 4'd4, 5'd1, 1'b1));
		plan.push_back(access_row(ACC_WRITE, 16'h2110, 8'h00));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_setup) begin
				settle_bus();
				set_config(plan[i].mapper, plan[i].rom_bits, plan[i].ram_banks,
					plan[i].has_ram);
			end else begin
				sender_gap();
				send_access(plan[i].kind, plan[i].addr, plan[i].wdata, plan[i].typed,
					plan[i].want);
			end
		end

		// Random phases. Each one settles the bus, picks new settings (the extremes come
		// first), runs a short well-formed bank setup and then a mixed access stream.
		for (phase = 0; phase < PHASES; phase++) begin
			settle_bus();
			case (phase)
				0: set_config(MBC_NONE, 4'd0, 5'd0, 1'b0);
				1: set_config(MBC_UNKNOWN_7, 4'd15, 5'd31, 1'b1);
				2: set_config(MBC_1, 4'd9, 5'd4, 1'b1);
				3: set_config(MBC_5, 4'd9, 5'd16, 1'b1);
				4: set_config(MBC_3, 4'd7, 5'd4, 1'b1);
				5: set_config(MBC_2, 4'd4, 5'd1, 1'b1);
				default: begin
					case ($urandom_range(0, 3))
						0: mapper = MBC_1;
						1: mapper = MBC_3;
						2: mapper = MBC_5;
						default: mapper = 3'($urandom_range(0, 7));
					endcase
					rom_bits  = 4'($urandom_range(0, 15));
					ram_banks = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
						: 5'($urandom_range(0, 8));
					has_ram   = ($urandom_range(0, 4) != 0);
					set_config(mapper, rom_bits, ram_banks, has_ram);
				end
			endcase

			// Some phases run with idling on one side only, some with none, and the
			// last one with none at all.
			quiet_phase = (phase == PHASES - 1);
			tx_idle_on  = ($urandom_range(0, 3) != 0);
			rx_idle_on  = ($urandom_range(0, 3) != 0);

			// Well-formed bring-up: enable RAM, pick a ROM bank, a RAM bank, a mode.
			sender_gap();
			send_access(ACC_WRITE, 16'($urandom_range(0, 16'h1FFF)) & 16'hFFEF,
				{4'($urandom_range(0, 15)), 4'hA}, 1'b0, '0);
			sender_gap();
			send_access(ACC_WRITE, 16'($urandom_range(16'h2000, 16'h3FFF)),
				8'($urandom_range(0, 255)), 1'b0, '0);
			sender_gap();
			send_access(ACC_WRITE, 16'($urandom_range(16'h4000, 16'h5FFF)),
				8'($urandom_range(0, 15)), 1'b0, '0);
			sender_gap();
			send_access(ACC_WRITE, 16'($urandom_range(16'h6000, 16'h7FFF)),
				8'($urandom_range(0, 255)), 1'b0, '0);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Once, the sink stops for a long stretch while accesses keep coming,
				// so the input register fills and s_tready has to fall.
				if (phase == HOLD_PHASE && n == 20)
					hold_request = 1'b1;

				wdata = 8'($urandom_range(0, 255));
				kind  = 1'($urandom_range(0, 1));
				pick  = $urandom_range(0, 99);
				if (pick < 20) begin
					// Mapper register write; RAM enable and small RAM banks are favored.
					kind = ACC_WRITE;
					addr = 16'($urandom_range(0, 16'h7FFF));
					if (addr < 16'h2000 && $urandom_range(0, 1) == 0)
						wdata = {wdata[7:4], 4'hA};
					else if (addr >= 16'h4000 && addr < 16'h6000 && $urandom_range(0, 2) != 0)
						wdata = 8'($urandom_range(0, 15));
				end else if (pick < 35) begin
					kind = ACC_READ;
					addr = 16'($urandom_range(0, 16'h7FFF));
				end else if (pick < 60) begin
					addr = 16'($urandom_range(16'hA000, 16'hBFFF));
				end else if (pick < 70) begin
					addr = 16'($urandom_range(16'hFE00, 16'hFFFF));
				end else if (pick < 80) begin
					addr = 16'($urandom_range(16'hFF00, 16'hFF7F));
				end else begin
					addr = 16'($urandom_range(0, 16'hFFFF));
				end
				sender_gap();
				send_access(kind, addr, wdata, 1'b0, '0);
			end

			// Mid-run, the source also waits for the block to drain completely before
			// it goes on.
			if (phase == HOLD_PHASE + 1)
				settle_bus();
		end

		// Everything offered: wait for the last results, then a little longer so a
		// stray extra result would still be caught.
		settle_bus();
		repeat (8) @(posedge clk);

		$display("Covered %0d bus accesses under %0d register settings; %0d results compared.",
			accesses_sent, settings_used, routes_checked);
		if (error_count == 0)
			$display("handheld_bus_decoder_with_bank_mapper_unit test passed");
		else
			$display("handheld_bus_decoder_with_bank_mapper_unit test failed");
		$finish;
	end

endmodule
